// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define JL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define JL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/jlsrp_pkg.sv =====
// ---------------------------------------------------------------------------
// jlsrp_pkg
// Shared widths, constants, state and opcode types of the step-rate profiler.
// ---------------------------------------------------------------------------
package jlsrp_pkg;

  // Field widths
  localparam int unsigned VelW     = 23;
  localparam int unsigned AccW     = 21;
  localparam int unsigned LimW     = 20;
  localparam int unsigned PwW      = 10;
  localparam int unsigned StateW   = 3;
  localparam int unsigned PerW     = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // Stream packing
  localparam int unsigned InDataW      = 24;
  localparam int unsigned OutAccLsb    = VelW;
  localparam int unsigned OutStepBit   = VelW + AccW;
  localparam int unsigned OutPerLsb    = OutStepBit + 1;
  localparam int unsigned OutUsedW     = OutPerLsb + PerW;
  localparam int unsigned OutDataW     = ((OutUsedW + 7) / 8) * 8;

  // Period divider: 256e6 / rate needs 28 numerator bits
  localparam int unsigned DivNumW  = 28;
  localparam int unsigned RemW     = VelW + 1;
  localparam int unsigned DivCntW  = $clog2(DivNumW);

  localparam int unsigned MaxRatePps = 20000;

  localparam logic [VelW-1:0]    VEL_MAX       = {VelW{1'b1}};
  localparam logic [VelW-1:0]    VEL_CLAMP     = VelW'(MaxRatePps * 256);
  localparam logic [VelW-1:0]    VEL_ONE_SPS   = VelW'(256);
  localparam logic [DivNumW-1:0] US_PER_S_X256 = DivNumW'(256000000);
  localparam logic [PerW-1:0]    RETRY_US      = PerW'(1000);
  localparam logic [PwW:0]       PW_MARGIN     = (PwW+1)'(5);

  // Run states
  localparam logic [StateW-1:0] RS_HOMING = 3'd2;
  localparam logic [StateW-1:0] RS_FAULT  = 3'd3;

  // Config register indexes
  localparam logic [CfgIdxW-1:0] CFG_S_CURVE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_JERK_STEP   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_WIDTH = 2'd3;

  // Config reset values
  localparam logic            RST_S_CURVE     = 1'b1;
  localparam logic [LimW-1:0] RST_ACCEL_LIMIT = LimW'(2560);
  localparam logic [LimW-1:0] RST_JERK_STEP   = LimW'(256);
  localparam logic [PwW-1:0]  RST_PULSE_WIDTH = PwW'(5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ACC,
    ST_VEL,
    ST_PERIOD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    KOP_HOLD,
    KOP_SET,
    KOP_DIFF,
    KOP_ACC,
    KOP_VEL
  } kin_op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== hdl/jlsrp_div.sv =====
// ---------------------------------------------------------------------------
// jlsrp_div
// Radix-2 restoring divider: 256e6 / rate, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module jlsrp_div import jlsrp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [VelW-1:0] divisor_i,
  output logic [PerW-1:0] quot_o,
  output div_sts_t        sts_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [PerW-1:0]    quot_q, quot_d;
  logic [VelW-1:0]    dvs_q, dvs_d;

  logic [DivCntW-1:0] bit_idx;
  logic [RemW-1:0]    rem_sh;
  logic [RemW:0]      diff;
  logic               fits;

  // Quotient stays below 2^20 for any rate above one step/s, so the
  // upper quotient bits shifted out are always zero.
  always_comb begin
    bit_idx = DivCntW'(DivNumW - 1) - cnt_q;
    rem_sh  = {rem_q[RemW-2:0], US_PER_S_X256[bit_idx]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_q};
    fits    = ~diff[RemW];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[RemW-1:0] : rem_sh;
      quot_d = {quot_q[PerW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o     = quot_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== hdl/jlsrp_kin.sv =====
// ---------------------------------------------------------------------------
// jlsrp_kin
// Velocity / acceleration state with a stepped jerk-limited update.
// ---------------------------------------------------------------------------
module jlsrp_kin import jlsrp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kin_op_e                op_i,
  input  logic [VelW-1:0]        goal_i,
  input  logic [LimW-1:0]        accel_limit_i,
  input  logic [LimW-1:0]        jerk_step_i,
  output logic [VelW-1:0]        velocity_o,
  output logic signed [AccW-1:0] accel_o
);

  logic [VelW-1:0]        vel_q, vel_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW:0]   da_q, da_d;

  logic signed [AccW-1:0] lim_pos;
  logic signed [AccW-1:0] agoal;
  logic signed [AccW:0]   js;
  logic signed [AccW:0]   da_clamp;
  logic signed [AccW:0]   acc_sum;
  logic signed [VelW+1:0] vel_sum;

  always_comb begin
    lim_pos = signed'({1'b0, accel_limit_i});
    js      = signed'({2'b00, jerk_step_i});

    if (vel_q < goal_i) begin
      agoal = lim_pos;
    end else if (vel_q > goal_i) begin
      agoal = -lim_pos;
    end else begin
      agoal = '0;
    end

    if (da_q > js) begin
      da_clamp = js;
    end else if (da_q < -js) begin
      da_clamp = -js;
    end else begin
      da_clamp = da_q;
    end

    acc_sum = (AccW+1)'(acc_q) + da_clamp;
    vel_sum = signed'({2'b00, vel_q}) + (VelW+2)'(acc_q);

    vel_d = vel_q;
    acc_d = acc_q;
    da_d  = da_q;

    case (op_i)
      KOP_SET: begin
        vel_d = goal_i;
        acc_d = '0;
      end
      KOP_DIFF: begin
        da_d = (AccW+1)'(agoal) - (AccW+1)'(acc_q);
      end
      KOP_ACC: begin
        // New value lies between old value and the limit, so it fits.
        acc_d = acc_sum[AccW-1:0];
      end
      KOP_VEL: begin
        if (vel_sum < 0) begin
          vel_d = '0;
        end else if (vel_sum > signed'({2'b00, VEL_MAX})) begin
          vel_d = VEL_MAX;
        end else begin
          vel_d = vel_sum[VelW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      acc_q <= '0;
    end else begin
      vel_q <= vel_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    da_q <= da_d;
  end

  assign velocity_o = vel_q;
  assign accel_o    = acc_q;

endmodule

// ===== hdl/jerk_limited_step_rate_profiler.sv =====
// ---------------------------------------------------------------------------
// jerk_limited_step_rate_profiler
// Per-tick S-curve or direct velocity update with step-period generation.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: run_state, tdata: target
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: vel, accel, stepping, period
//  cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
//  A request passes ST_DIFF, ST_ACC and ST_VEL with the ramp, or ST_DIFF only
//  with it off (homing, fault, direct mode), then ST_PERIOD; a stepping result
//  waits in ST_DIV on the restoring divider (one of 28 numerator bits per
//  cycle). Input is not ready while a request is in work and is ready again
//  once the result is in the output register, even if it is stalled. Reset
//  clears velocity and acceleration and loads the register defaults; cfg_ready_o is tied high.
//
module jerk_limited_step_rate_profiler import jlsrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input requests
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [StateW-1:0]   s_axis_tuser,   // [2:0] run_state
  input  logic [InDataW-1:0]  s_axis_tdata,   // [22:0] target_velocity, [23] zero
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [22:0] velocity, [43:23] acceleration,
                                              // [44] stepping, [64:45] step_period_us,
                                              // [71:65] zero
  // config writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Config registers
  logic            s_curve_q;
  logic [LimW-1:0] accel_limit_q;
  logic [LimW-1:0] jerk_step_q;
  logic [PwW-1:0]  pulse_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_curve_q     <= RST_S_CURVE;
      accel_limit_q <= RST_ACCEL_LIMIT;
      jerk_step_q   <= RST_JERK_STEP;
      pulse_width_q <= RST_PULSE_WIDTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_S_CURVE:     s_curve_q     <= cfg_data_i[0];
        CFG_ACCEL_LIMIT: accel_limit_q <= cfg_data_i[LimW-1:0];
        CFG_JERK_STEP:   jerk_step_q   <= cfg_data_i[LimW-1:0];
        CFG_PULSE_WIDTH: pulse_width_q <= cfg_data_i[PwW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and per-request registers
  state_e              state_q, state_d;
  logic [StateW-1:0]   rs_q;
  logic [VelW-1:0]     goal_q;
  logic                stepping_q, stepping_d;
  logic [PerW-1:0]     period_q, period_d;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic                load_in;
  logic                load_out;
  logic                div_start;
  kin_op_e             kin_op;

  logic [VelW-1:0]        velocity;
  logic signed [AccW-1:0] accel;
  logic [PerW-1:0]        quot;
  div_sts_t               div_sts;

  logic                use_ramp;
  logic                moving;
  logic [VelW-1:0]     vc;
  logic                step_now;
  logic [PwW:0]        min_period;

  jlsrp_kin u_kin (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (kin_op),
    .goal_i        (goal_q),
    .accel_limit_i (accel_limit_q),
    .jerk_step_i   (jerk_step_q),
    .velocity_o    (velocity),
    .accel_o       (accel)
  );

  jlsrp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (vc),
    .quot_o    (quot),
    .sts_o     (div_sts)
  );

  always_comb begin
    // Homing and fault bypass the ramp; fault with goal zero lands on 0/0.
    use_ramp   = s_curve_q && (rs_q != RS_HOMING) && (rs_q != RS_FAULT);
    moving     = (rs_q <= RS_HOMING);
    vc         = (velocity > VEL_CLAMP) ? VEL_CLAMP : velocity;
    step_now   = moving && (vc > VEL_ONE_SPS);
    min_period = {1'b0, pulse_width_q} + PW_MARGIN;

    state_d    = state_q;
    stepping_d = stepping_q;
    period_d   = period_q;
    load_in    = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    kin_op     = KOP_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          load_in = 1'b1;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (use_ramp) begin
          kin_op  = KOP_DIFF;
          state_d = ST_ACC;
        end else begin
          kin_op  = KOP_SET;
          state_d = ST_PERIOD;
        end
      end
      ST_ACC: begin
        kin_op  = KOP_ACC;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        kin_op  = KOP_VEL;
        state_d = ST_PERIOD;
      end
      ST_PERIOD: begin
        stepping_d = step_now;
        if (step_now) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          period_d = RETRY_US;
          state_d  = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          period_d = (quot < PerW'(min_period)) ? PerW'(min_period) : quot;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait for the output register to free up
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    stepping_q <= stepping_d;
    period_q   <= period_d;
    if (load_in) begin
      rs_q   <= s_axis_tuser;
      // Fault, idle and unknown states drive toward zero
      goal_q <= (s_axis_tuser >= RS_FAULT) ? '0 : s_axis_tdata[VelW-1:0];
    end
    if (load_out) begin
      out_data_q <= {(OutDataW-OutUsedW)'(0), period_q, stepping_q, accel, velocity};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/jlsrp_chk.sv =====
// ---------------------------------------------------------------------------
// jlsrp_chk
// Port-level checks of the step-rate profiler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jlsrp_chk import jlsrp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [StateW-1:0]   s_axis_tuser,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  logic            out_step;
  logic [PerW-1:0] out_period;
  logic [VelW-1:0] out_vel;

  assign out_step   = m_axis_tdata[OutStepBit];
  assign out_period = m_axis_tdata[OutPerLsb +: PerW];
  assign out_vel    = m_axis_tdata[VelW-1:0];

  `JL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `JL_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready right after a request")
  `JL_ASSERT(a_retry_period, m_axis_tvalid && !out_step |-> out_period == RETRY_US, "idle period not retry")
  `JL_ASSERT(a_step_rate, m_axis_tvalid && out_step |-> out_vel > VEL_ONE_SPS && out_period > PerW'(PW_MARGIN), "stepping with bad rate or period")
  `JL_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind jerk_limited_step_rate_profiler jlsrp_chk u_chk (.*);

// ===== tb/sv/jerk_limited_step_rate_profiler_chk.sv =====
// ----------------------------------------------------------------------------
// Step-rate profiler result checker
// Watches the tick, result and register channels, keeps its own copy of the
// velocity/acceleration state and the registers, and compares every result
// field with the profile it predicts for the oldest accepted tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jerk_limited_step_rate_profiler_chk import jlsrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [StateW-1:0]   s_axis_tuser,   // [2:0] run_state
  input  logic [InDataW-1:0]  s_axis_tdata,   // [22:0] target_velocity
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // [22:0] velocity, [43:23] acceleration,
                                              // [44] stepping, [64:45] step_period_us
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Same bit order as the result tdata (last member lands in the low bits).
  typedef struct packed {
    logic [PerW-1:0] period;
    logic            stepping;
    logic [AccW-1:0] accel;
    logic [VelW-1:0] vel;
  } profile_t;

  logic     scurve_q;
  longint   accel_lim_q;
  longint   jerk_q;
  longint   pulse_w_q;
  longint   vel_q;
  longint   acc_q;
  profile_t profile_q[$];

  // Advances the kinematic state by one tick and returns the resulting profile.
  function automatic profile_t advance_profile(logic [StateW-1:0] rs,
                                               logic [VelW-1:0] target);
    longint   goal;
    longint   acc_goal;
    longint   dacc;
    longint   vc;
    longint   period;
    logic     moving;
    profile_t res;
    goal   = longint'(target);
    moving = (rs <= RS_HOMING);
    if (rs == RS_FAULT) begin
      vel_q = 0;
      acc_q = 0;
      goal  = 0;
    end else if (rs > RS_FAULT) begin
      goal = 0;   // idle and undefined states stop
    end
    if (scurve_q && rs != RS_HOMING) begin
      if (vel_q < goal)      acc_goal = accel_lim_q;
      else if (vel_q > goal) acc_goal = -accel_lim_q;
      else                   acc_goal = 0;
      dacc = acc_goal - acc_q;
      if (dacc > jerk_q)  dacc = jerk_q;
      if (dacc < -jerk_q) dacc = -jerk_q;
      acc_q = acc_q + dacc;
      vel_q = vel_q + acc_q;
      if (vel_q < 0) vel_q = 0;
      if (vel_q > longint'(VEL_MAX)) vel_q = longint'(VEL_MAX);
    end else begin
      vel_q = goal;
      acc_q = 0;
    end
    vc = (vel_q > longint'(VEL_CLAMP)) ? longint'(VEL_CLAMP) : vel_q;
    res.stepping = moving && (vc > longint'(VEL_ONE_SPS));
    if (res.stepping) begin
      period = longint'(US_PER_S_X256) / vc;
      if (period < pulse_w_q + longint'(PW_MARGIN)) period = pulse_w_q + longint'(PW_MARGIN);
    end else begin
      period = longint'(RETRY_US);
    end
    res.vel    = vel_q[VelW-1:0];
    res.accel  = acc_q[AccW-1:0];
    res.period = period[PerW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    profile_t want;
    profile_t got;
    if (!rst_ni) begin
      scurve_q     = RST_S_CURVE;
      accel_lim_q  = longint'(RST_ACCEL_LIMIT);
      jerk_q       = longint'(RST_JERK_STEP);
      pulse_w_q    = longint'(RST_PULSE_WIDTH);
      vel_q        = 0;
      acc_q        = 0;
      profile_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_S_CURVE:     scurve_q    = cfg_data_i[0];
          CFG_ACCEL_LIMIT: accel_lim_q = longint'(cfg_data_i[LimW-1:0]);
          CFG_JERK_STEP:   jerk_q      = longint'(cfg_data_i[LimW-1:0]);
          CFG_PULSE_WIDTH: pulse_w_q   = longint'(cfg_data_i[PwW-1:0]);
          default: ;
        endcase
      end
      // results first: a result never belongs to the tick taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutUsedW-1:0];
        if (profile_q.size() == 0) begin
          $error("result with no tick pending: tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = profile_q.pop_front();
          if (got.vel !== want.vel) begin
            $error("velocity: expected %0d, got %0d", want.vel, got.vel);
            fail_count_o++;
          end
          if (got.accel !== want.accel) begin
            $error("acceleration: expected %0d, got %0d",
                   $signed(want.accel), $signed(got.accel));
            fail_count_o++;
          end
          if (got.stepping !== want.stepping) begin
            $error("stepping: expected %0d, got %0d", want.stepping, got.stepping);
            fail_count_o++;
          end
          if (got.period !== want.period) begin
            $error("step_period_us: expected %0d, got %0d", want.period, got.period);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        profile_q.push_back(advance_profile(s_axis_tuser, s_axis_tdata[VelW-1:0]));
      pending_o = profile_q.size();
    end
  end

endmodule

// ===== tb/sv/jerk_limited_step_rate_profiler_tb.sv =====
// ----------------------------------------------------------------------------
// Step-rate profiler testbench
// Drives control ticks and register writes into the profiler, with random
// idle cycles on both stream sides, a long output hold-off and drain pauses.
// The checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jerk_limited_step_rate_profiler_tb;
  import jlsrp_pkg::*;

  // Run states the package leaves unnamed
  localparam logic [StateW-1:0] RS_RUNNING     = 3'd0;
  localparam logic [StateW-1:0] RS_ROTATING    = 3'd1;
  localparam logic [StateW-1:0] RS_IDLE        = 3'd4;
  localparam logic [StateW-1:0] RS_UNDEF_FIRST = 3'd5;
  localparam logic [StateW-1:0] RS_UNDEF_LAST  = 3'd7;

  localparam logic [LimW-1:0] LIM_MAX = {LimW{1'b1}};

  localparam int IDLE_PCT       = 11;
  localparam int HOLD_CYCLES    = 400;   // output hold-off, fills the block
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int NUM_PHASES     = 15;
  localparam int PHASE_ITEMS    = 105;
  localparam int QUIET_PHASE    = 2;     // no idling on either side
  localparam int HOLD_PHASE     = 4;
  localparam int TAIL_CYCLES    = 60;    // longer than the slowest request

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [StateW-1:0]   s_axis_tuser;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int   fail_count;
  int   pending_results;
  int   quiet_cycles;
  logic idle_on;     // random idling enabled on both sides
  logic hold_req;    // sender asks the receiver for a long hold-off

  jerk_limited_step_rate_profiler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  jerk_limited_step_rate_profiler_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any accepted request, result or register write restarts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  // While held off the block parks one result and one tick, then stalls input.
  initial begin
    int   hold_left;
    logic hold_taken;
    hold_left     = 0;
    hold_taken    = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken    = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // One tick request; valid stays high into the next request unless a gap
  // is inserted.
  task automatic send_tick(input logic [StateW-1:0] rs, input logic [VelW-1:0] tgt);
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = rs;
    s_axis_tdata  = InDataW'(tgt);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering ticks until every predicted result has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Registers change only with the block empty. Unused upper bits of the
  // narrow registers carry noise; the block must ignore them.
  task automatic set_profile(input logic en, input logic [LimW-1:0] lim,
                             input logic [LimW-1:0] js, input logic [PwW-1:0] pw);
    drain();
    write_reg(CFG_S_CURVE,     {19'($urandom_range(0, 524287)), en});
    write_reg(CFG_ACCEL_LIMIT, lim);
    write_reg(CFG_JERK_STEP,   js);
    write_reg(CFG_PULSE_WIDTH, {10'($urandom_range(0, 1023)), pw});
  endtask

  // Limits spread over orders of magnitude so ramps range from crawling to
  // saturating within a few ticks.
  function automatic logic [LimW-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return LimW'($urandom_range(0, 255));
      1:       return LimW'($urandom_range(256, 8191));
      2:       return LimW'($urandom_range(8192, 131071));
      default: return LimW'($urandom_range(131072, 1048575));
    endcase
  endfunction

  // Mostly moving states; fault, idle and undefined states as noise.
  function automatic logic [StateW-1:0] pick_state();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      return StateW'($urandom_range(RS_RUNNING, RS_ROTATING));
    else if (r < 82) return RS_HOMING;
    else if (r < 88) return RS_FAULT;
    else if (r < 95) return RS_IDLE;
    else             return StateW'($urandom_range(RS_UNDEF_FIRST, RS_UNDEF_LAST));
  endfunction

  function automatic logic [VelW-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      return VelW'($urandom_range(0, 20000));
    else if (r < 80) return VelW'($urandom_range(0, VEL_CLAMP));
    else if (r < 90) return VelW'($urandom_range(0, VEL_MAX));
    else begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return VEL_ONE_SPS;
        2:       return VEL_ONE_SPS + 1'b1;
        default: return VEL_CLAMP;
      endcase
    end
  endfunction

  initial begin
    int               sent;
    int               seg_len;
    logic [StateW-1:0] rs;
    logic [VelW-1:0]   tgt;

    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    #1;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: default registers, ramp up, over-range target, idle and
    // undefined states, homing (direct follow) around the one step/s edge,
    // fault clearing.
    send_tick(RS_RUNNING, '0);
    send_tick(RS_RUNNING, VEL_CLAMP);
    send_tick(RS_RUNNING, VEL_CLAMP);
    send_tick(RS_ROTATING, VEL_MAX);
    send_tick(RS_IDLE, 23'h555555);
    send_tick(RS_UNDEF_LAST, 23'h2AAAAA);
    send_tick(RS_HOMING, VEL_CLAMP);
    send_tick(RS_HOMING, VEL_MAX);        // rate clamps at the max step rate
    send_tick(RS_HOMING, VEL_ONE_SPS);    // exactly 1 step/s: not stepping
    send_tick(RS_HOMING, VEL_ONE_SPS + 1'b1);
    send_tick(RS_RUNNING, VEL_ONE_SPS + 1'b1);
    send_tick(RS_FAULT, VEL_CLAMP);
    send_tick(RS_UNDEF_FIRST, 23'd100);

    // Direct mode, widest pulse (period floor wins), then zero pulse width
    set_profile(1'b0, RST_ACCEL_LIMIT, RST_JERK_STEP, PwW'(1000));
    send_tick(RS_RUNNING, VEL_CLAMP);
    send_tick(RS_ROTATING, VEL_MAX);
    set_profile(1'b0, RST_ACCEL_LIMIT, RST_JERK_STEP, '0);
    send_tick(RS_RUNNING, VEL_CLAMP);

    // Largest limit and jerk: velocity saturates, then brakes toward zero
    set_profile(1'b1, LIM_MAX, LIM_MAX, PwW'(1023));
    repeat (6) send_tick(RS_RUNNING, VEL_MAX);
    repeat (2) send_tick(RS_IDLE, '0);

    // Zero limit and jerk: acceleration frozen where it was
    set_profile(1'b1, '0, '0, PwW'(1));
    repeat (2) send_tick(RS_RUNNING, VEL_CLAMP);

    // Random phases: each a fresh register set, ticks in runs of one state
    // with a slowly changing target.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_profile($urandom_range(0, 3) != 0, pick_limit(), pick_limit(),
                  ($urandom_range(0, 3) == 0) ? PwW'($urandom_range(0, 1023))
                                              : PwW'($urandom_range(1, 30)));
      idle_on = (phase != QUIET_PHASE);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        rs      = pick_state();
        tgt     = pick_target();
        seg_len = (rs == RS_FAULT) ? $urandom_range(1, 3) : $urandom_range(1, 40);
        for (int k = 0; k < seg_len && sent < PHASE_ITEMS; k++) begin
          if ($urandom_range(0, 9) == 0) tgt = pick_target();
          send_tick(rs, tgt);
          sent++;
          if (phase == HOLD_PHASE && sent == 20) hold_req = 1'b1;
          if ($urandom_range(0, 199) == 0) drain();
        end
      end
    end
    idle_on = 1'b1;

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
